// File: hw/rtl/opl_pkg.sv
// Shared widths, codes, payload types and control structs for the ordered list.
package opl_pkg;

  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned ENTRY_WIDTH_DEF = 32;

  localparam int unsigned MODE_W      = 3;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned FIDX_W      = 6;
  localparam int unsigned CNT_FIELD_W = 7;

  localparam logic [MODE_W-1:0] MODE_GET    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd5;

  localparam logic [KIND_W-1:0] KIND_EXPLICIT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END      = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FAIL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [KIND_W-1:0]  position_kind;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [VALUE_W-1:0]     read_value;
    logic [FIDX_W-1:0]      found_index;
    logic [CNT_FIELD_W-1:0] entry_count;
  } rsp_t;

  // Read address sources; the sweep pointer follows the read address on every read.
  typedef enum logic [2:0] {
    RD_IDX,
    RD_LAST,
    RD_ZERO,
    RD_IDX_INC,
    RD_PTR_INC,
    RD_PTR_DEC
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_VAL_AT_COUNT,
    WR_VAL_AT_IDX,
    WR_UP,
    WR_DOWN
  } wr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    logic                load_req;
    logic                rd_en;
    rd_sel_e             rd_sel;
    wr_op_e              wr_op;
    cnt_op_e             cnt_op;
    logic                stg_clear;
    logic                stg_status_en;
    logic [STATUS_W-1:0] stg_status;
    logic                stg_value_en;
    logic                stg_index_en;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              kind_ok;
    logic              idx_lt_cnt;
    logic              idx_le_cnt;
    logic              idx_eq_cnt;
    logic              idx_is_last;
    logic              full;
    logic              empty;
    logic              val_zero;
    logic              match;
    logic              ptr_at_idx;
    logic              ptr_at_last;
  } stat_t;

endpackage

// File: hw/rtl/opl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module opl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hw/rtl/opl_ctrl.sv
// Controller state machine that sequences each list request over the datapath.
module opl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  opl_pkg::stat_t stat_i,
  output opl_pkg::cmd_t  cmd_o
);

  import opl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GETW,
    S_FIND,
    S_SHUP,
    S_INSW,
    S_SHDN,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_req = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.stg_clear     = 1'b1;
        cmd_o.stg_status_en = 1'b1;
        cmd_o.stg_status    = STATUS_FAIL;
        state_d             = S_DONE;
        unique case (stat_i.mode)
          MODE_GET: begin
            if (stat_i.kind_ok && stat_i.idx_lt_cnt) begin
              cmd_o.rd_en      = 1'b1;
              cmd_o.rd_sel     = RD_IDX;
              cmd_o.stg_status = STATUS_OK;
              state_d          = S_GETW;
            end else begin
              cmd_o.stg_status = STATUS_NOT_FOUND;
            end
          end
          MODE_FIND: begin
            cmd_o.stg_status = STATUS_NOT_FOUND;
            if (!stat_i.empty) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_ZERO;
              state_d      = S_FIND;
            end
          end
          MODE_INSERT: begin
            if (stat_i.kind_ok && stat_i.idx_le_cnt && !stat_i.full) begin
              cmd_o.stg_status = STATUS_OK;
              if (stat_i.idx_eq_cnt) begin
                cmd_o.wr_op  = WR_VAL_AT_IDX;
                cmd_o.cnt_op = CNT_INC;
              end else begin
                // Move entries up starting from the top one.
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = RD_LAST;
                state_d      = S_SHUP;
              end
            end
          end
          MODE_REMOVE: begin
            if (stat_i.kind_ok && stat_i.idx_lt_cnt) begin
              cmd_o.stg_status = STATUS_OK;
              if (stat_i.idx_is_last) begin
                cmd_o.cnt_op = CNT_DEC;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = RD_IDX_INC;
                state_d      = S_SHDN;
              end
            end else begin
              cmd_o.stg_status = STATUS_NOT_FOUND;
            end
          end
          MODE_PUSH: begin
            if (!stat_i.val_zero && !stat_i.full) begin
              cmd_o.wr_op      = WR_VAL_AT_COUNT;
              cmd_o.cnt_op     = CNT_INC;
              cmd_o.stg_status = STATUS_OK;
            end
          end
          MODE_POP: begin
            if (stat_i.empty) begin
              cmd_o.stg_status = STATUS_EMPTY;
            end else begin
              cmd_o.rd_en      = 1'b1;
              cmd_o.rd_sel     = RD_LAST;
              cmd_o.cnt_op     = CNT_DEC;
              cmd_o.stg_status = STATUS_OK;
              state_d          = S_GETW;
            end
          end
          default: begin
            cmd_o.stg_status = STATUS_FAIL;
          end
        endcase
      end
      S_GETW: begin
        cmd_o.stg_value_en = 1'b1;
        state_d            = S_DONE;
      end
      S_FIND: begin
        if (stat_i.match) begin
          cmd_o.stg_index_en  = 1'b1;
          cmd_o.stg_status_en = 1'b1;
          cmd_o.stg_status    = STATUS_OK;
          state_d             = S_DONE;
        end else if (stat_i.ptr_at_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR_INC;
        end
      end
      S_SHUP: begin
        cmd_o.wr_op = WR_UP;
        if (stat_i.ptr_at_idx) begin
          state_d = S_INSW;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR_DEC;
        end
      end
      S_INSW: begin
        cmd_o.wr_op  = WR_VAL_AT_IDX;
        cmd_o.cnt_op = CNT_INC;
        state_d      = S_DONE;
      end
      S_SHDN: begin
        cmd_o.wr_op = WR_DOWN;
        if (stat_i.ptr_at_last) begin
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR_INC;
        end
      end
      S_DONE: begin
        // The output register takes the result once its previous transfer is done.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DECODE))
    else $error("accepted request did not move to decode");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cmd_o.wr_op == WR_NONE && cmd_o.cnt_op == CNT_HOLD))
    else $error("list modified while idle");

endmodule

// File: hw/rtl/opl_dp.sv
// Datapath: request registers, entry count, sweep pointer, entry RAM and result registers.
module opl_dp #(
  parameter int unsigned CAPACITY    = opl_pkg::CAPACITY_DEF,
  parameter int unsigned ENTRY_WIDTH = opl_pkg::ENTRY_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  opl_pkg::req_t  in_req_i,
  input  opl_pkg::cmd_t  cmd_i,
  output opl_pkg::stat_t stat_o,
  output opl_pkg::rsp_t  out_rsp_o
);

  import opl_pkg::*;

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [MODE_W-1:0]      mode_q;
  logic                   kind_ok_q, kind_ok_d;
  logic [CMP_W-1:0]       idx_q, idx_d;
  logic [ENTRY_WIDTH-1:0] val_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [AW-1:0]          ptr_q;
  logic [STATUS_W-1:0]    res_status_q;
  logic [ENTRY_WIDTH-1:0] res_value_q;
  logic [AW-1:0]          res_index_q;
  rsp_t                   out_q;

  logic [CNT_W-1:0]       cnt_last;
  logic [CMP_W-1:0]       idx_inc;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [ENTRY_WIDTH-1:0] wr_data;
  logic [ENTRY_WIDTH-1:0] rd_data;

  assign cnt_last = count_q - CNT_W'(1);
  assign idx_inc  = idx_q + CMP_W'(1);

  // The list end resolves against the count as it stands when the request arrives.
  always_comb begin
    idx_d     = '0;
    kind_ok_d = 1'b1;
    unique case (in_req_i.position_kind)
      KIND_EXPLICIT: idx_d = CMP_W'(in_req_i.position);
      KIND_START:    idx_d = '0;
      KIND_END:      idx_d = CMP_W'(count_q);
      default:       kind_ok_d = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX:     rd_addr = idx_q[AW-1:0];
      RD_LAST:    rd_addr = cnt_last[AW-1:0];
      RD_ZERO:    rd_addr = '0;
      RD_IDX_INC: rd_addr = idx_inc[AW-1:0];
      RD_PTR_INC: rd_addr = ptr_q + AW'(1);
      RD_PTR_DEC: rd_addr = ptr_q - AW'(1);
      default:    rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = val_q;
    unique case (cmd_i.wr_op)
      WR_NONE:         wr_en = 1'b0;
      WR_VAL_AT_COUNT: wr_addr = count_q[AW-1:0];
      WR_VAL_AT_IDX:   wr_addr = idx_q[AW-1:0];
      WR_UP: begin
        wr_addr = ptr_q + AW'(1);
        wr_data = rd_data;
      end
      WR_DOWN: begin
        wr_addr = ptr_q - AW'(1);
        wr_data = rd_data;
      end
      default:         wr_en = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.cnt_op)
      CNT_HOLD: count_d = count_q;
      CNT_INC:  count_d = count_q + CNT_W'(1);
      CNT_DEC:  count_d = count_q - CNT_W'(1);
      default:  count_d = count_q;
    endcase
  end

  opl_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      mode_q    <= in_req_i.mode;
      kind_ok_q <= kind_ok_d;
      idx_q     <= idx_d;
      val_q     <= ENTRY_WIDTH'(in_req_i.value);
    end
    if (cmd_i.rd_en) begin
      ptr_q <= rd_addr;
    end
    if (cmd_i.stg_clear) begin
      res_value_q <= '0;
      res_index_q <= '0;
    end
    if (cmd_i.stg_value_en) begin
      res_value_q <= rd_data;
    end
    if (cmd_i.stg_index_en) begin
      res_index_q <= ptr_q;
    end
    if (cmd_i.stg_status_en) begin
      res_status_q <= cmd_i.stg_status;
    end
    if (cmd_i.out_load) begin
      out_q.status      <= res_status_q;
      out_q.read_value  <= VALUE_W'(res_value_q);
      out_q.found_index <= FIDX_W'(res_index_q);
      out_q.entry_count <= CNT_FIELD_W'(count_q);
    end
  end

  assign stat_o.mode        = mode_q;
  assign stat_o.kind_ok     = kind_ok_q;
  assign stat_o.idx_lt_cnt  = idx_q < CMP_W'(count_q);
  assign stat_o.idx_le_cnt  = idx_q <= CMP_W'(count_q);
  assign stat_o.idx_eq_cnt  = idx_q == CMP_W'(count_q);
  assign stat_o.idx_is_last = idx_q == CMP_W'(cnt_last);
  assign stat_o.full        = count_q == CNT_W'(CAPACITY);
  assign stat_o.empty       = count_q == '0;
  assign stat_o.val_zero    = val_q == '0;
  assign stat_o.match       = rd_data == val_q;
  assign stat_o.ptr_at_idx  = CMP_W'(ptr_q) == idx_q;
  assign stat_o.ptr_at_last = CNT_W'(ptr_q) == cnt_last;

  assign out_rsp_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_inc_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cnt_op == CNT_INC) |-> (count_q < CNT_W'(CAPACITY)))
    else $error("entry added to a full list");

  a_no_dec_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cnt_op == CNT_DEC) |-> (count_q != '0))
    else $error("entry taken from an empty list");

endmodule

// File: hw/rtl/ordered_pointer_list.sv
// Push, failed and trivial requests go from decode straight to the result; get and pop first
// read one entry. Find sweeps from the first entry until a match or the last entry; insert
// moves entries up from the top down to the index, and remove moves those above the index down.
// Throughput: one request in service at a time; the next is taken in the cycle its result is
// first offered. A stalled output register holds the result and the next request back.
// Reset empties the list at once; entry contents are left undefined and are never read.
module ordered_pointer_list #(
  parameter int unsigned CAPACITY    = opl_pkg::CAPACITY_DEF,
  parameter int unsigned ENTRY_WIDTH = opl_pkg::ENTRY_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  opl_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output opl_pkg::rsp_t out_rsp_o
);

  import opl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  opl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  opl_dp #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_rsp_o (out_rsp_o)
  );

endmodule
